// ===== sv/e2r_pkg.sv =====
// Shared constants, types and elaboration-time functions of the Euler-to-rotation-matrix block.
package e2r_pkg;

    // Field formats
    localparam int ANGLE_W       = 16;
    localparam int FIELD_W       = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int LANES         = 3;
    localparam int LANE_ROLL     = 0;
    localparam int LANE_PITCH    = 1;
    localparam int LANE_YAW      = 2;

    // Angle limit of 180 degrees in units of 1/128 degree, and its split 2^9 * 45
    localparam int ANGLE_LIMIT = 23040;
    localparam int ANGLE_SHIFT = 9;
    localparam int ANGLE_ODD   = ANGLE_LIMIT >> ANGLE_SHIFT;

    // pi in Q60 and Q29
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam longint PI_Q29      = longint'((PI_Q60 + (64'd1 << 30)) >> 31);
    localparam longint HALF_PI_Q29 = PI_Q29 >>> 1;
    localparam longint ONE_Q30     = longint'(64'd1 << 30);

    // Degree to radian conversion: angle * PI_Q29 / ANGLE_LIMIT as quotient and remainder parts
    localparam int MAG_W   = 15;
    localparam int CQ_W    = 17;
    localparam int HI_W    = 31;
    localparam int LO_W    = 28;
    localparam int Q_W     = 14;
    localparam int RP_W    = 40;
    localparam int REC_SHIFT = 25;
    localparam longint CONV_Q  = PI_Q29 / ANGLE_LIMIT;
    localparam longint CONV_R  = PI_Q29 % ANGLE_LIMIT;
    localparam longint REC_MUL = ((64'd1 << REC_SHIFT) + ANGLE_ODD - 1) / ANGLE_ODD;

    // Datapath widths
    localparam int Z_W    = 33;
    localparam int XY_W   = 34;
    localparam int TRIG_W = 32;
    localparam int PROD_W = 64;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic                  flip;
    } e2r_ang_t;

    typedef struct packed {
        e2r_ang_t roll;
        e2r_ang_t pitch;
        e2r_ang_t yaw;
    } e2r_item_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } e2r_sc_t;

    typedef struct packed {
        e2r_sc_t roll;
        e2r_sc_t pitch;
        e2r_sc_t yaw;
    } e2r_trig_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } e2r_qstat_t;

    // Shift-subtract unsigned divide, used for constants only
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q29 from the Q62 arctangent series
    function automatic logic [63:0] atan_q29(int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        if (i == 0)
        begin
            return (PI_Q60 + (64'd1 << 32)) >> 33;
        end
        for (int k = 0; k < 32; k++)
        begin
            e = i * (2 * k + 1);
            if (e <= 62)
            begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return (sum + (64'd1 << 32)) >> 33;
    endfunction

    // CORDIC start value: 2^60 / isqrt(2^60 * gain^2), rounded
    function automatic logic [63:0] start_x();
        logic [63:0] g;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] probe;
        logic [63:0] s;
        g = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            g = g + (g >> (2 * i));
        end
        v     = g;
        res   = '0;
        probe = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (probe > v)
                probe = probe >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (probe != 0)
            begin
                if (v >= res + probe)
                begin
                    v   = v - (res + probe);
                    res = (res >> 1) + probe;
                end
                else
                begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
        end
        s = res;
        if (s == 0)
            s = 64'd1;
        return udiv64((64'd1 << 60) + (s >> 1), s);
    endfunction

    // Round v / 2^sh to nearest, ties away from zero
    function automatic logic signed [PROD_W-1:0] rnd_q(logic signed [PROD_W-1:0] v, int sh);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        r   = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
        return v[PROD_W-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ===== sv/euler_to_rotation_matrix.sv =====
// Top level of the Euler ZYX angle to rotation matrix block.
//
// Takes one request of roll, pitch and yaw (signed, 1/128 degree) on the
// input channel and returns the nine Q1.14 elements of Rz(yaw)*Ry(pitch)*Rx(roll).
// Both channels move a request at a clock edge where valid is high and stall low.
// Throughput: one request per cycle while out_stall stays low. Every stage is a plain pipeline
// stage; nothing is shared or iterated.
// Stages in order: 3 front stages for saturation, degree-to-radian conversion
// and quadrant fold, the 4-entry queue, a load stage, 16 CORDIC stages and one
// for sign and clamp, 5 product and rounding stages.
// Reset clears all valid bits and the queue; no clearing pass is needed.
// When out_stall and out_valid are both high the whole back end holds its results;
// the front end keeps accepting until the queue fills, then raises in_stall.
module euler_to_rotation_matrix
    import e2r_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  logic signed [ANGLE_W-1:0] yaw_angle,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [FIELD_W-1:0] m00,
    output logic signed [FIELD_W-1:0] m01,
    output logic signed [FIELD_W-1:0] m02,
    output logic signed [FIELD_W-1:0] m10,
    output logic signed [FIELD_W-1:0] m11,
    output logic signed [FIELD_W-1:0] m12,
    output logic signed [FIELD_W-1:0] m20,
    output logic signed [FIELD_W-1:0] m21,
    output logic signed [FIELD_W-1:0] m22
);

    localparam int ONE_FIELD = (OUT_FRAC_BITS <= 14) ? (1 << OUT_FRAC_BITS) : 32767;

    logic       front_adv;
    logic       front_valid;
    e2r_item_t  front_item;
    logic       push;
    logic       pop;
    e2r_item_t  head_item;
    e2r_qstat_t q_stat;
    logic       back_adv;
    logic       trig_valid;
    e2r_trig_t  trig;

    // Stall the front only when its last stage cannot drain
    assign front_adv = !(front_valid && q_stat.full);
    assign in_stall  = !front_adv;
    assign push      = front_valid && !q_stat.full;

    // Freeze the back while a result waits
    assign back_adv = !(out_valid && out_stall);
    assign pop      = back_adv && !q_stat.empty;

    e2r_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (front_adv),
        .in_valid    (in_valid),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .item_valid  (front_valid),
        .item        (front_item)
    );

    e2r_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (head_item),
        .status    (q_stat)
    );

    e2r_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (back_adv),
        .in_valid  (pop),
        .in_item   (head_item),
        .out_valid (trig_valid),
        .out_trig  (trig)
    );

    e2r_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (back_adv),
        .in_valid  (trig_valid),
        .in_trig   (trig),
        .out_valid (out_valid),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22)
    );

    // Queue fill never exceeds its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    // Fill count tracks pushes and pops
    a_queue_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (q_stat.count == $past(q_stat.count) + QCNT_W'($past(push))
                                  - QCNT_W'($past(pop))))
        else $error("queue fill count out of step with push and pop");

    // Saturated element m20 stays within plus or minus one
    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(m20) <= ONE_FIELD && int'(m20) >= -ONE_FIELD))
        else $error("matrix element beyond unit range");

endmodule

// ===== sv/e2r_front.sv =====
// Front end: saturate each angle, convert it to radians and fold it into a quarter turn.
module e2r_front
    import e2r_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  logic signed [ANGLE_W-1:0] yaw_angle,
    output logic                      item_valid,
    output e2r_item_t                 item
);

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(ANGLE_LIMIT);

    logic signed [ANGLE_W-1:0] angle [LANES];
    logic                      neg1_reg [LANES];
    logic [HI_W-1:0]           hi1_reg [LANES];
    logic [LO_W-1:0]           lo1_reg [LANES];
    logic                      neg2_reg [LANES];
    logic [HI_W-1:0]           hi2_reg [LANES];
    logic [Q_W-1:0]            q2_reg [LANES];
    e2r_ang_t                  ang3_reg [LANES];
    logic [2:0]                v_reg;

    assign angle[LANE_ROLL]  = roll_angle;
    assign angle[LANE_PITCH] = pitch_angle;
    assign angle[LANE_YAW]   = yaw_angle;

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[1:0], in_valid};
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [ANGLE_W-1:0] sat;
        logic [MAG_W-1:0]          mag;
        logic [LO_W-ANGLE_SHIFT-1:0] rec_in;
        logic [RP_W-1:0]           rec_prod;
        logic [HI_W-1:0]           m_sum;
        logic signed [Z_W-1:0]     mz;
        e2r_ang_t                  ang_next;

        // Saturate to a half turn and take the magnitude
        always_comb
        begin
            if (angle[l] > ANGLE_MAX)
                sat = ANGLE_MAX;
            else if (angle[l] < -ANGLE_MAX)
                sat = -ANGLE_MAX;
            else
                sat = angle[l];
            mag = sat[ANGLE_W-1] ? MAG_W'(-sat) : MAG_W'(sat);
        end

        // Divide the remainder part by 2^9 * 45 through a shift and a reciprocal
        assign rec_in   = lo1_reg[l][LO_W-1:ANGLE_SHIFT];
        assign rec_prod = RP_W'(rec_in) * RP_W'(REC_MUL);

        // Fold beyond a quarter turn by a half turn toward zero
        assign m_sum = hi2_reg[l] + HI_W'(q2_reg[l]);
        assign mz    = $signed(Z_W'(m_sum));
        always_comb
        begin
            if (m_sum > HI_W'(HALF_PI_Q29))
            begin
                ang_next.z    = neg2_reg[l] ? Z_W'(PI_Q29) - mz : mz - Z_W'(PI_Q29);
                ang_next.flip = 1'b1;
            end
            else
            begin
                ang_next.z    = neg2_reg[l] ? -mz : mz;
                ang_next.flip = 1'b0;
            end
        end

        // Hold payload while stalled
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                neg1_reg[l] <= sat[ANGLE_W-1];
                hi1_reg[l]  <= HI_W'(HI_W'(mag) * HI_W'(CONV_Q));
                lo1_reg[l]  <= LO_W'(LO_W'(mag) * LO_W'(CONV_R)) + LO_W'(ANGLE_LIMIT / 2);
                neg2_reg[l] <= neg1_reg[l];
                hi2_reg[l]  <= hi1_reg[l];
                q2_reg[l]   <= Q_W'(rec_prod >> REC_SHIFT);
                ang3_reg[l] <= ang_next;
            end
        end
    end

    assign item_valid = v_reg[2];
    assign item.roll  = ang3_reg[LANE_ROLL];
    assign item.pitch = ang3_reg[LANE_PITCH];
    assign item.yaw   = ang3_reg[LANE_YAW];

endmodule

// ===== sv/e2r_queue.sv =====
// Short request queue that decouples the front end from the back end.
module e2r_queue
    import e2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  e2r_item_t  push_item,
    input  logic       pop,
    output e2r_item_t  pop_item,
    output e2r_qstat_t status
);

    e2r_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // Store a request
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

// ===== sv/e2r_cordic.sv =====
// Back end, first part: pipelined rotation-mode CORDIC, one stage per iteration, three lanes.
module e2r_cordic
    import e2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_valid,
    input  e2r_item_t in_item,
    output logic      out_valid,
    output e2r_trig_t out_trig
);

    localparam logic signed [XY_W-1:0] X_START = XY_W'(start_x());
    localparam logic signed [XY_W-1:0] ONE_XY  = XY_W'(ONE_Q30);

    e2r_ang_t                ang_in [LANES];
    logic signed [XY_W-1:0]  x_reg [LANES][CORDIC_STAGES+1];
    logic signed [XY_W-1:0]  y_reg [LANES][CORDIC_STAGES+1];
    logic signed [Z_W-1:0]   z_reg [LANES][CORDIC_STAGES+1];
    logic                    flip_reg [LANES][CORDIC_STAGES+1];
    e2r_sc_t                 sc_reg [LANES];
    logic [CORDIC_STAGES+1:0] v_reg;

    assign ang_in[LANE_ROLL]  = in_item.roll;
    assign ang_in[LANE_PITCH] = in_item.pitch;
    assign ang_in[LANE_YAW]   = in_item.yaw;

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[CORDIC_STAGES:0], in_valid};
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [XY_W-1:0] y_sgn;
        logic signed [XY_W-1:0] x_sgn;

        // Load a request into the first stage
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[l][0]    <= X_START;
                y_reg[l][0]    <= '0;
                z_reg[l][0]    <= ang_in[l].z;
                flip_reg[l][0] <= ang_in[l].flip;
            end
        end

        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(atan_q29(i));
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;

            assign dx = y_reg[l][i] >>> i;
            assign dy = x_reg[l][i] >>> i;

            // Rotate toward zero residual angle
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    if (!z_reg[l][i][Z_W-1])
                    begin
                        x_reg[l][i+1] <= x_reg[l][i] - dx;
                        y_reg[l][i+1] <= y_reg[l][i] + dy;
                        z_reg[l][i+1] <= z_reg[l][i] - ATAN_I;
                    end
                    else
                    begin
                        x_reg[l][i+1] <= x_reg[l][i] + dx;
                        y_reg[l][i+1] <= y_reg[l][i] - dy;
                        z_reg[l][i+1] <= z_reg[l][i] + ATAN_I;
                    end
                    flip_reg[l][i+1] <= flip_reg[l][i];
                end
            end
        end

        // Undo the half-turn fold and clamp to plus or minus one
        assign y_sgn = flip_reg[l][CORDIC_STAGES] ? -y_reg[l][CORDIC_STAGES]
                                                  : y_reg[l][CORDIC_STAGES];
        assign x_sgn = flip_reg[l][CORDIC_STAGES] ? -x_reg[l][CORDIC_STAGES]
                                                  : x_reg[l][CORDIC_STAGES];

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (y_sgn > ONE_XY)
                    sc_reg[l].s <= TRIG_W'(ONE_XY);
                else if (y_sgn < -ONE_XY)
                    sc_reg[l].s <= TRIG_W'(-ONE_XY);
                else
                    sc_reg[l].s <= TRIG_W'(y_sgn);
                if (x_sgn > ONE_XY)
                    sc_reg[l].c <= TRIG_W'(ONE_XY);
                else if (x_sgn < -ONE_XY)
                    sc_reg[l].c <= TRIG_W'(-ONE_XY);
                else
                    sc_reg[l].c <= TRIG_W'(x_sgn);
            end
        end
    end

    assign out_valid      = v_reg[CORDIC_STAGES+1];
    assign out_trig.roll  = sc_reg[LANE_ROLL];
    assign out_trig.pitch = sc_reg[LANE_PITCH];
    assign out_trig.yaw   = sc_reg[LANE_YAW];

endmodule

// ===== sv/e2r_matrix.sv =====
// Back end, second part: product pipeline that forms and rounds the nine matrix elements.
module e2r_matrix
    import e2r_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  e2r_trig_t          in_trig,
    output logic               out_valid,
    output logic [FIELD_W-1:0] m00,
    output logic [FIELD_W-1:0] m01,
    output logic [FIELD_W-1:0] m02,
    output logic [FIELD_W-1:0] m10,
    output logic [FIELD_W-1:0] m11,
    output logic [FIELD_W-1:0] m12,
    output logic [FIELD_W-1:0] m20,
    output logic [FIELD_W-1:0] m21,
    output logic [FIELD_W-1:0] m22
);

    localparam int OUT_SHIFT = 60 - OUT_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ONE_OUT = PROD_W'(1) <<< OUT_FRAC_BITS;

    function automatic logic [FIELD_W-1:0] to_field(logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        r = rnd_q(v, OUT_SHIFT);
        if (r > ONE_OUT)
            r = ONE_OUT;
        else if (r < -ONE_OUT)
            r = -ONE_OUT;
        return r[FIELD_W-1:0];
    endfunction

    logic signed [TRIG_W-1:0] sr, cr, sp, cp, sy, cy;
    logic [4:0]               v_reg;

    // Stage one products
    logic signed [PROD_W-1:0] p1_srsp_reg, p1_crsp_reg, p1_cpcy_reg, p1_cpsy_reg, p1_srsy_reg;
    logic signed [PROD_W-1:0] p1_crsy_reg, p1_srcy_reg, p1_crcy_reg, p1_srcp_reg, p1_crcp_reg;
    logic signed [TRIG_W-1:0] sp1_reg, cy1_reg, sy1_reg;
    // Stage two rounded partial products
    logic signed [TRIG_W-1:0] srsp2_reg, crsp2_reg, sp2_reg, cy2_reg, sy2_reg;
    logic signed [PROD_W-1:0] p2_cpcy_reg, p2_cpsy_reg, p2_srsy_reg, p2_crsy_reg;
    logic signed [PROD_W-1:0] p2_srcy_reg, p2_crcy_reg, p2_srcp_reg, p2_crcp_reg;
    // Stage three triple products
    logic signed [PROD_W-1:0] q3_srspcy_reg, q3_srspsy_reg, q3_crspcy_reg, q3_crspsy_reg;
    logic signed [PROD_W-1:0] p3_cpcy_reg, p3_cpsy_reg, p3_srsy_reg, p3_crsy_reg;
    logic signed [PROD_W-1:0] p3_srcy_reg, p3_crcy_reg, p3_srcp_reg, p3_crcp_reg;
    logic signed [TRIG_W-1:0] sp3_reg;
    // Stage four elements in Q60
    logic signed [PROD_W-1:0] e4_reg [9];
    // Stage five output fields
    logic [FIELD_W-1:0]       f5_reg [9];

    assign sr = in_trig.roll.s;
    assign cr = in_trig.roll.c;
    assign sp = in_trig.pitch.s;
    assign cp = in_trig.pitch.c;
    assign sy = in_trig.yaw.s;
    assign cy = in_trig.yaw.c;

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[3:0], in_valid};
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_srsp_reg <= PROD_W'(sr) * PROD_W'(sp);
            p1_crsp_reg <= PROD_W'(cr) * PROD_W'(sp);
            p1_cpcy_reg <= PROD_W'(cp) * PROD_W'(cy);
            p1_cpsy_reg <= PROD_W'(cp) * PROD_W'(sy);
            p1_srsy_reg <= PROD_W'(sr) * PROD_W'(sy);
            p1_crsy_reg <= PROD_W'(cr) * PROD_W'(sy);
            p1_srcy_reg <= PROD_W'(sr) * PROD_W'(cy);
            p1_crcy_reg <= PROD_W'(cr) * PROD_W'(cy);
            p1_srcp_reg <= PROD_W'(sr) * PROD_W'(cp);
            p1_crcp_reg <= PROD_W'(cr) * PROD_W'(cp);
            sp1_reg     <= sp;
            cy1_reg     <= cy;
            sy1_reg     <= sy;

            srsp2_reg   <= TRIG_W'(rnd_q(p1_srsp_reg, 30));
            crsp2_reg   <= TRIG_W'(rnd_q(p1_crsp_reg, 30));
            sp2_reg     <= sp1_reg;
            cy2_reg     <= cy1_reg;
            sy2_reg     <= sy1_reg;
            p2_cpcy_reg <= p1_cpcy_reg;
            p2_cpsy_reg <= p1_cpsy_reg;
            p2_srsy_reg <= p1_srsy_reg;
            p2_crsy_reg <= p1_crsy_reg;
            p2_srcy_reg <= p1_srcy_reg;
            p2_crcy_reg <= p1_crcy_reg;
            p2_srcp_reg <= p1_srcp_reg;
            p2_crcp_reg <= p1_crcp_reg;

            q3_srspcy_reg <= PROD_W'(srsp2_reg) * PROD_W'(cy2_reg);
            q3_srspsy_reg <= PROD_W'(srsp2_reg) * PROD_W'(sy2_reg);
            q3_crspcy_reg <= PROD_W'(crsp2_reg) * PROD_W'(cy2_reg);
            q3_crspsy_reg <= PROD_W'(crsp2_reg) * PROD_W'(sy2_reg);
            p3_cpcy_reg   <= p2_cpcy_reg;
            p3_cpsy_reg   <= p2_cpsy_reg;
            p3_srsy_reg   <= p2_srsy_reg;
            p3_crsy_reg   <= p2_crsy_reg;
            p3_srcy_reg   <= p2_srcy_reg;
            p3_crcy_reg   <= p2_crcy_reg;
            p3_srcp_reg   <= p2_srcp_reg;
            p3_crcp_reg   <= p2_crcp_reg;
            sp3_reg       <= sp2_reg;

            e4_reg[0] <= p3_cpcy_reg;
            e4_reg[1] <= q3_srspcy_reg - p3_crsy_reg;
            e4_reg[2] <= q3_crspcy_reg + p3_srsy_reg;
            e4_reg[3] <= p3_cpsy_reg;
            e4_reg[4] <= q3_srspsy_reg + p3_crcy_reg;
            e4_reg[5] <= q3_crspsy_reg - p3_srcy_reg;
            e4_reg[6] <= -(PROD_W'(sp3_reg) <<< 30);
            e4_reg[7] <= p3_srcp_reg;
            e4_reg[8] <= p3_crcp_reg;

            for (int e = 0; e < 9; e++)
            begin
                f5_reg[e] <= to_field(e4_reg[e]);
            end
        end
    end

    assign out_valid = v_reg[4];
    assign m00 = f5_reg[0];
    assign m01 = f5_reg[1];
    assign m02 = f5_reg[2];
    assign m10 = f5_reg[3];
    assign m11 = f5_reg[4];
    assign m12 = f5_reg[5];
    assign m20 = f5_reg[6];
    assign m21 = f5_reg[7];
    assign m22 = f5_reg[8];

endmodule

// ===== tb/e2r_matrix_checker.sv =====
// Checker of the Euler-to-rotation-matrix block: predicts each matrix and compares the results.
`timescale 1ns / 100ps

module e2r_matrix_checker
    import e2r_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  logic signed [ANGLE_W-1:0] yaw_angle,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [FIELD_W-1:0] m00,
    input  logic signed [FIELD_W-1:0] m01,
    input  logic signed [FIELD_W-1:0] m02,
    input  logic signed [FIELD_W-1:0] m10,
    input  logic signed [FIELD_W-1:0] m11,
    input  logic signed [FIELD_W-1:0] m12,
    input  logic signed [FIELD_W-1:0] m20,
    input  logic signed [FIELD_W-1:0] m21,
    input  logic signed [FIELD_W-1:0] m22,
    output int                        mismatch_count,
    output int                        matrices_pending
);

    typedef logic [8:0][FIELD_W-1:0] matrix_t;

    longint  atan_tab [32];
    longint  pi_rad;
    longint  x_seed;
    matrix_t matrix_queue [$];

    // Round to nearest, ties away from zero
    function automatic longint round_shift(longint v, int sh);
        longint mag;
        longint r;
        mag = v < 0 ? -v : v;
        r   = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return v < 0 ? -r : r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Build arctangent table, pi and the gain-corrected start value
    initial
    begin
        longint          sum;
        longint          term;
        longint unsigned g;
        longint unsigned s;
        longint          pi60;
        pi60   = longint'(PI_Q60);
        pi_rad = round_shift(pi60, 31);
        for (int i = 0; i < 32; i++)
        begin
            sum = 0;
            if (i == 0)
                atan_tab[i] = round_shift(pi60, 33);
            else
            begin
                for (int k = 0; i * (2 * k + 1) <= 62; k++)
                begin
                    term = (longint'(1) << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
                    sum  = (k % 2) ? sum - term : sum + term;
                end
                atan_tab[i] = round_shift(sum, 33);
            end
        end
        g = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++)
            g = g + (g >> (2 * i));
        s = int_sqrt(g);
        if (s == 0)
            s = 1;
        x_seed = longint'(((64'd1 << 60) + (s >> 1)) / s);
    end

    function automatic longint clamp_one(longint v);
        if (v > ONE_Q30)
            return ONE_Q30;
        if (v < -ONE_Q30)
            return -ONE_Q30;
        return v;
    endfunction

    // Sine and cosine of one angle field, Q30
    task automatic angle_sin_cos(input logic signed [15:0] field, output longint sn,
                                 output longint cs);
        longint a;
        longint m;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        a    = field;
        flip = 0;
        if (a > ANGLE_LIMIT)
            a = ANGLE_LIMIT;
        if (a < -ANGLE_LIMIT)
            a = -ANGLE_LIMIT;
        m = (a < 0 ? -a : a) * pi_rad;
        m = (m + ANGLE_LIMIT / 2) / ANGLE_LIMIT;
        z = a < 0 ? -m : m;
        // fold a angle beyond a quarter turn by a half turn
        if (z > (pi_rad >>> 1))
        begin
            z    = z - pi_rad;
            flip = 1;
        end
        else if (z < -(pi_rad >>> 1))
        begin
            z    = z + pi_rad;
            flip = 1;
        end
        x = x_seed;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sn = clamp_one(y);
        cs = clamp_one(x);
    endtask

    function automatic logic [FIELD_W-1:0] to_element(longint q60);
        longint one;
        longint v;
        one = longint'(1) << OUT_FRAC_BITS;
        v   = round_shift(q60, 60 - OUT_FRAC_BITS);
        if (v > one)
            v = one;
        if (v < -one)
            v = -one;
        return v[FIELD_W-1:0];
    endfunction

    task automatic predict_matrix(input logic signed [15:0] r, input logic signed [15:0] p,
                                  input logic signed [15:0] yw, output matrix_t mat);
        longint sr, cr, sp, cp, sy, cy, srsp, crsp;
        angle_sin_cos(r, sr, cr);
        angle_sin_cos(p, sp, cp);
        angle_sin_cos(yw, sy, cy);
        srsp   = round_shift(sr * sp, 30);
        crsp   = round_shift(cr * sp, 30);
        mat[0] = to_element(cp * cy);
        mat[1] = to_element(srsp * cy - cr * sy);
        mat[2] = to_element(crsp * cy + sr * sy);
        mat[3] = to_element(cp * sy);
        mat[4] = to_element(srsp * sy + cr * cy);
        mat[5] = to_element(crsp * sy - sr * cy);
        mat[6] = to_element(-sp * ONE_Q30);
        mat[7] = to_element(sr * cp);
        mat[8] = to_element(cr * cp);
    endtask

    assign matrices_pending = matrix_queue.size();

    // Append a prediction per accepted request, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        matrix_t pred;
        matrix_t got;
        bit      bad;
        if (!rst_n)
        begin
            mismatch_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_matrix(roll_angle, pitch_angle, yaw_angle, pred);
                matrix_queue = {matrix_queue, pred};
            end
            if (out_valid && !out_stall)
            begin
                got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
                if (matrix_queue.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result %h", got);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    pred = matrix_queue.pop_front();
                    bad  = 0;
                    for (int e = 0; e < 9; e++)
                    begin
                        if (got[e] !== pred[e])
                        begin
                            bad = 1;
                            if (mismatch_count < 10)
                                $display("element m%0d%0d expected %0d actual %0d", e / 3,
                                         e % 3, $signed(pred[e]), $signed(got[e]));
                        end
                    end
                    if (bad)
                        mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

endmodule

// ===== tb/euler_to_rotation_matrix_tb.sv =====
// Top of the Euler-to-rotation-matrix testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module euler_to_rotation_matrix_tb;
    import e2r_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 1900;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    int                        mismatch_count;
    int                        matrices_pending;
    bit                        busy_phase;
    bit                        hold_request;
    int                        idle_cycles = 0;

    euler_to_rotation_matrix i_dut (.*);

    e2r_matrix_checker i_checker (.*);

    initial
        clk = 0;
    always #5 clk = ~clk;

    // Draw a random wait, none during busy phases
    function automatic int draw_gap();
        return busy_phase ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic send_request(input logic [15:0] r, input logic [15:0] p,
                                input logic [15:0] yw);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        roll_angle  <= r;
        pitch_angle <= p;
        yaw_angle   <= yw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [15:0] random_angle();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT);
    endfunction

    // Receiver: stall a random while per result, or hold off long on request
    initial
    begin
        int w;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_request = 0;
            end
            w = draw_gap();
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Watchdog: count cycles with no accepted request on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] corner [14];
        in_valid     <= 1'b0;
        roll_angle   <= '0;
        pitch_angle  <= '0;
        yaw_angle    <= '0;
        busy_phase   = 0;
        hold_request = 0;
        rst_n        = 1'b0;
        corner = '{16'd0, 16'd1, -16'sd1, 16'd23040, -16'sd23040, 16'd11520, -16'sd11520,
                   16'd11521, -16'sd11521, 16'd23041, -16'sd23041, 16'h7FFF, 16'h8000,
                   16'd5760};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each corner angle on every axis, then gimbal lock and half-turn poses
        for (int i = 0; i < 14; i++)
            send_request(corner[i], corner[13 - i], corner[(i + 5) % 14]);
        send_request(16'd3000, 16'd11520, -16'sd7000);
        send_request(-16'sd9000, -16'sd11520, 16'd20000);
        send_request(16'd23040, 16'd23040, 16'd23040);
        send_request(-16'sd23040, -16'sd23040, -16'sd23040);

        // Fill the block while the receiver holds off
        busy_phase   = 1;
        hold_request = 1;
        for (int i = 0; i < 60; i++)
            send_request(random_angle(), random_angle(), random_angle());
        busy_phase = 0;

        // Random requests in phases of mixed and back-to-back traffic
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                busy_phase = ($urandom_range(0, 2) == 0);
            if (i == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (matrices_pending != 0)
                    @(posedge clk);
            end
            send_request(random_angle(), random_angle(), random_angle());
        end
        in_valid <= 1'b0;

        while (matrices_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && matrices_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
